@@ rtl/dns_relay_query_id_table_unit_assert.svh @@
// assertion macros shared by the dns relay query id table rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef DNS_RELAY_QUERY_ID_TABLE_UNIT_ASSERT_SVH
`define DNS_RELAY_QUERY_ID_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every edge out of reset
`define DNSR_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("dnsr assertion failed");

// consequence holds in the cycle after the trigger
`define DNSR_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("dnsr assertion failed");

`else

`define DNSR_ASSERT_ALWAYS(label, clk, rstn, cond)
`define DNSR_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

@@ rtl/dnsr_pkg.sv @@
// types and constants of the dns relay query id table
// no dependencies; used by dns_relay_query_id_table_unit
package dnsr_pkg;

    localparam int ID_W    = 16;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int AGE_W   = 16;
    localparam int LIMIT_W = 4;
    localparam int REM_W   = 4;

    localparam int unsigned AGE_SCALE_MS = 1000;

    localparam logic [AGE_W-1:0]   AGE_RESET   = 16'd60;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    // configuration register indexes
    localparam logic REG_AGE_SECONDS = 1'b0;
    localparam logic REG_KEEP_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_SWEEP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_ADDED      = 3'd0,
        STAT_RETRANS    = 3'd1,
        STAT_REPLY_HIT  = 3'd2,
        STAT_REPLY_MISS = 3'd3,
        STAT_SWEEP_DONE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   local_id;
        logic [ID_W-1:0]   client_id;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

@@ rtl/dns_relay_query_id_table_unit.sv @@
// dns relay query id translation table, top level
// depends on dnsr_pkg and dns_relay_query_id_table_unit_assert.svh
//
// Usage: one command per s_ transaction, one result per m_ transaction.
// s_tuser carries the command: add a client query, find the owner of a reply
// by local id, or sweep old entries. The table is a ring of TABLE_DEPTH
// entries, oldest first, held in one synchronous memory with one read port.
// Add and find walk the ring from the oldest entry, one memory read per
// cycle; a sweep walks the same way and pops entries while they are removable.
// After accept the walk stops on the entry it seeks (for a sweep, the first
// entry it keeps) or runs to the end of the ring; an add that misses then
// writes its entry, and the result is loaded into the output register that
// drives m_tvalid. One command is handled at a time; the next is accepted
// as soon as its result sits in the output register, even while m_tready is low.
// A command code of 3 is accepted and dropped with no result.
// Reset empties the ring, clears the local id counter and loads age_seconds
// with 60 and keep_limit with 5; memory contents are left as they are.
// A stalled receiver holds the result in the output register; the block then
// finishes at most one further command and waits before delivering it.
// Configuration writes are taken at any edge with cfg_wr_en high, unless aresetn is low.
`include "dns_relay_query_id_table_unit_assert.svh"

module dns_relay_query_id_table_unit #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // query_id[15:0], client_addr[47:16], client_port[63:48], now_ms[95:64]
    input  logic [95:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // id_out[15:0], addr_out[47:16], port_out[63:48], removed_count[67:64], zero[71:68]
    output logic [71:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W   = dnsr_pkg::LIMIT_W;
    localparam int CMP_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int RM_W    = dnsr_pkg::REM_W;
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W+1)'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        if (nxt >= DEPTH_X) begin
            nxt = '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    // entry memory
    dnsr_pkg::entry_t mem [TABLE_DEPTH];

    // control state
    dnsr_pkg::state_t     state_reg, state_next;
    logic [IDX_W-1:0]     oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [15:0]          next_id_reg, next_id_next;
    logic [15:0]          age_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // payload
    dnsr_pkg::cmd_t       cmd_reg, cmd_next;
    logic [15:0]          qid_reg, qid_next;
    logic [31:0]          addr_reg, addr_next;
    logic [15:0]          port_reg, port_next;
    logic [31:0]          now_reg, now_next;
    logic [31:0]          cutoff_reg, cutoff_next;
    logic [IDX_W-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;
    dnsr_pkg::status_t    res_status_reg, res_status_next;
    logic [15:0]          res_id_reg, res_id_next;
    logic [31:0]          res_addr_reg, res_addr_next;
    logic [15:0]          res_port_reg, res_port_next;
    dnsr_pkg::entry_t     rd_data_reg;
    logic [71:0]          m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;

    logic                 in_fire;
    logic                 out_free;
    logic [31:0]          age_ms;
    logic                 issue_more;
    logic                 cid_hit;
    logic                 lid_hit;
    logic                 keep_head;
    logic                 stop;
    logic                 exhausted;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 full;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    dnsr_pkg::entry_t     wr_entry;

    assign s_tready = (state_reg == dnsr_pkg::S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign age_ms   = 32'(age_reg) * 32'(dnsr_pkg::AGE_SCALE_MS);

    assign issue_more = issue_reg < len_reg;
    assign cid_hit    = rd_data_reg.client_id == qid_reg;
    assign lid_hit    = rd_data_reg.local_id == qid_reg;
    // head stays unless it is too old or the ring holds more than the limit
    assign keep_head  = !((rd_data_reg.stamp < cutoff_reg) ||
                          (CMP_W'(count_reg) > CMP_W'(limit_reg)));

    always_comb begin
        stop = 1'b0;
        if (rd_vld_reg) begin
            case (cmd_reg)
                dnsr_pkg::CMD_ADD:   stop = cid_hit;
                dnsr_pkg::CMD_FIND:  stop = lid_hit;
                dnsr_pkg::CMD_SWEEP: stop = keep_head;
                default:             stop = 1'b1;
            endcase
        end
    end

    assign exhausted = !stop && !issue_more && !rd_vld_reg;
    assign rd_en     = (state_reg == dnsr_pkg::S_SCAN) && !stop && issue_more;
    assign rd_addr   = slot_at(base_reg, issue_reg[IDX_W-1:0]);

    // full ring: the oldest entry is evicted and its slot is reused
    assign full     = count_reg == DEPTH_C;
    assign mem_we   = state_reg == dnsr_pkg::S_WRITE;
    assign wr_addr  = full ? oldest_reg : slot_at(oldest_reg, count_reg[IDX_W-1:0]);
    assign wr_entry = '{local_id:  next_id_reg,
                        client_id: qid_reg,
                        addr:      addr_reg,
                        port:      port_reg,
                        stamp:     now_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dnsr_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (s_tuser)
                        dnsr_pkg::CMD_ADD,
                        dnsr_pkg::CMD_FIND,
                        dnsr_pkg::CMD_SWEEP: state_next = dnsr_pkg::S_SCAN;
                        default:             state_next = dnsr_pkg::S_IDLE;
                    endcase
                end
            end
            dnsr_pkg::S_SCAN: begin
                if (stop) begin
                    state_next = dnsr_pkg::S_DONE;
                end else if (exhausted) begin
                    state_next = (cmd_reg == dnsr_pkg::CMD_ADD) ? dnsr_pkg::S_WRITE
                                                                : dnsr_pkg::S_DONE;
                end
            end
            dnsr_pkg::S_WRITE: begin
                state_next = dnsr_pkg::S_DONE;
            end
            dnsr_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = dnsr_pkg::S_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next        = cmd_reg;
        qid_next        = qid_reg;
        addr_next       = addr_reg;
        port_next       = port_reg;
        now_next        = now_reg;
        cutoff_next     = cutoff_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        issue_next      = issue_reg;
        removed_next    = removed_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_addr_next   = res_addr_reg;
        res_port_next   = res_port_reg;
        rd_vld_next     = rd_en;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            dnsr_pkg::S_IDLE: begin
                if (in_fire) begin
                    cmd_next      = dnsr_pkg::cmd_t'(s_tuser);
                    qid_next      = s_tdata[15:0];
                    addr_next     = s_tdata[47:16];
                    port_next     = s_tdata[63:48];
                    now_next      = s_tdata[95:64];
                    cutoff_next   = s_tdata[95:64] - age_ms;
                    base_next     = oldest_reg;
                    len_next      = count_reg;
                    issue_next    = '0;
                    removed_next  = '0;
                    res_id_next   = '0;
                    res_addr_next = '0;
                    res_port_next = '0;
                end
            end
            dnsr_pkg::S_SCAN: begin
                if (rd_en) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (rd_vld_reg && (cmd_reg == dnsr_pkg::CMD_SWEEP) && !keep_head) begin
                    oldest_next  = ring_inc(oldest_reg);
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end
                case (cmd_reg)
                    dnsr_pkg::CMD_ADD: begin
                        if (stop) begin
                            res_status_next = dnsr_pkg::STAT_RETRANS;
                            res_id_next     = rd_data_reg.local_id;
                        end
                    end
                    dnsr_pkg::CMD_FIND: begin
                        if (stop) begin
                            res_status_next = dnsr_pkg::STAT_REPLY_HIT;
                            res_id_next     = rd_data_reg.client_id;
                            res_addr_next   = rd_data_reg.addr;
                            res_port_next   = rd_data_reg.port;
                        end else begin
                            res_status_next = dnsr_pkg::STAT_REPLY_MISS;
                        end
                    end
                    default: begin
                        res_status_next = dnsr_pkg::STAT_SWEEP_DONE;
                    end
                endcase
            end
            dnsr_pkg::S_WRITE: begin
                if (full) begin
                    oldest_next  = ring_inc(oldest_reg);
                    removed_next = CNT_W'(1);
                end else begin
                    count_next = count_reg + 1'b1;
                end
                next_id_next    = next_id_reg + 1'b1;
                res_status_next = dnsr_pkg::STAT_ADDED;
                res_id_next     = next_id_reg;
            end
            dnsr_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, RM_W'(removed_reg), res_port_reg,
                                     res_addr_reg, res_id_reg};
                    m_tuser_next  = res_status_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dnsr_pkg::S_IDLE;
            oldest_reg   <= '0;
            count_reg    <= '0;
            next_id_reg  <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            age_reg      <= dnsr_pkg::AGE_RESET;
            limit_reg    <= dnsr_pkg::LIMIT_RESET;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    dnsr_pkg::REG_AGE_SECONDS: age_reg   <= cfg_wdata;
                    dnsr_pkg::REG_KEEP_LIMIT:  limit_reg <= cfg_wdata[LIM_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        qid_reg        <= qid_next;
        addr_reg       <= addr_next;
        port_reg       <= port_next;
        now_reg        <= now_next;
        cutoff_reg     <= cutoff_next;
        base_reg       <= base_next;
        len_reg        <= len_next;
        removed_reg    <= removed_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_addr_reg   <= res_addr_next;
        res_port_reg   <= res_port_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DNSR_ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, count_reg <= DEPTH_C)
    `DNSR_ASSERT_ALWAYS(a_oldest_in_range, aclk, aresetn, {1'b0, oldest_reg} < DEPTH_X)
    `DNSR_ASSERT_NEXT(a_write_leaves_entry, aclk, aresetn, state_reg == dnsr_pkg::S_WRITE, count_reg != '0)
    `DNSR_ASSERT_NEXT(a_scan_never_grows, aclk, aresetn, state_reg == dnsr_pkg::S_SCAN, count_reg <= $past(count_reg))
    `DNSR_ASSERT_NEXT(a_result_waits, aclk, aresetn, (state_reg == dnsr_pkg::S_DONE) && m_tvalid_reg && !m_tready, state_reg == dnsr_pkg::S_DONE)

endmodule

@@ tb/sv/dns_relay_query_id_table_unit_tb.sv @@
// self-checking testbench for the dns relay query id translation table
// depends on dnsr_pkg and dns_relay_query_id_table_unit; keeps its own model of the ring
`timescale 1ns / 1ps

module dns_relay_query_id_table_unit_tb;

    localparam int TABLE_DEPTH     = 8;
    localparam int TAIL_CYCLES     = TABLE_DEPTH + 12;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 63;

    // command code with no meaning: accepted and dropped by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        dnsr_pkg::status_t         status;
        logic [dnsr_pkg::ID_W-1:0] id;
        logic [31:0]               addr;
        logic [15:0]               port;
        logic [3:0]                removed;
    } reply_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] qid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] now;
        bit          typed;
        reply_t      reply;
    } dir_row_t;

    localparam reply_t NO_REPLY = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    // shadow of the ring, oldest entry at ring_head
    logic [15:0] ring_local_id  [TABLE_DEPTH];
    logic [15:0] ring_client_id [TABLE_DEPTH];
    logic [31:0] ring_addr      [TABLE_DEPTH];
    logic [15:0] ring_port      [TABLE_DEPTH];
    logic [31:0] ring_stamp     [TABLE_DEPTH];
    int          ring_head    = 0;
    int          ring_fill    = 0;
    logic [15:0] ring_next_id = '0;
    logic [15:0] rule_age_s   = dnsr_pkg::AGE_RESET;
    logic [3:0]  rule_keep    = dnsr_pkg::LIMIT_RESET;

    reply_t      pending_replies [$];
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 59;
    int unsigned hold_ticket  = 0;
    int unsigned hold_served  = 0;

    dir_row_t directed_rows [24] = '{
        '{dnsr_pkg::CMD_ADD, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1,
          '{dnsr_pkg::STAT_ADDED, 16'h0000, 32'h0, 16'h0, 4'd0}},
        '{dnsr_pkg::CMD_FIND, 16'hffff, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1,
          '{dnsr_pkg::STAT_REPLY_MISS, 16'h0000, 32'h0, 16'h0, 4'd0}},
        // cutoff wraps below zero, so the entry counts as old
        '{dnsr_pkg::CMD_SWEEP, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'hffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'hffff, 32'h1234_5678, 16'h4321, 32'h0000_1000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_FIND, 16'h0001, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{CMD_UNUSED, 16'hffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_SWEEP, 16'h0000, 32'h0000_0000, 16'h0000, 32'hffff_ffff, 1'b0, NO_REPLY},
        // fill the ring; the last add evicts the oldest entry
        '{dnsr_pkg::CMD_ADD, 16'h1000, 32'ha5a5_5a5a, 16'h0035, 32'd100000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1001, 32'h5a5a_a5a5, 16'hcafe, 32'd100010, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1002, 32'hc0a8_0001, 16'h8000, 32'd100020, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1003, 32'h0a00_0002, 16'h0001, 32'd100030, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1004, 32'h7f00_0001, 16'h7fff, 32'd100040, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1005, 32'h8000_0000, 16'h1234, 32'd100050, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1006, 32'h0000_0001, 16'hfffe, 32'd100060, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1007, 32'hfffe_fffe, 16'h5555, 32'd100070, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_FIND, 16'h0001, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_FIND, 16'h0009, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_ADD, 16'h1003, 32'h0000_0000, 16'h0000, 32'd100080, 1'b0, NO_REPLY},
        // first sweep trims by count, second by age
        '{dnsr_pkg::CMD_SWEEP, 16'h0000, 32'h0000_0000, 16'h0000, 32'd100000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_SWEEP, 16'h0000, 32'h0000_0000, 16'h0000, 32'd200000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_FIND, 16'h0009, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, NO_REPLY},
        '{dnsr_pkg::CMD_SWEEP, 16'h0000, 32'h0000_0000, 16'h0000, 32'd200000, 1'b1,
          '{dnsr_pkg::STAT_SWEEP_DONE, 16'h0000, 32'h0, 16'h0, 4'd0}}
    };

    int unsigned phase_age  [PHASES] = '{0, 65535, 1, 5, 60, 2};
    int unsigned phase_keep [PHASES] = '{8, 0, 15, 3, 5, 8};

    dns_relay_query_id_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // advances the shadow ring by one command; returns 0 when no result follows
    function automatic bit relay_table_step(input logic [1:0] cmd, input logic [15:0] qid,
                                            input logic [31:0] addr, input logic [15:0] port,
                                            input logic [31:0] now, output reply_t r);
        int slot;
        logic [31:0] cutoff;
        r = '0;
        case (cmd)
            dnsr_pkg::CMD_ADD: begin
                for (int k = 0; k < ring_fill; k++) begin
                    slot = (ring_head + k) % TABLE_DEPTH;
                    if (ring_client_id[slot] == qid) begin
                        r.status = dnsr_pkg::STAT_RETRANS;
                        r.id     = ring_local_id[slot];
                        return 1'b1;
                    end
                end
                if (ring_fill >= TABLE_DEPTH) begin
                    ring_head = (ring_head + 1) % TABLE_DEPTH;
                    ring_fill--;
                    r.removed = 4'd1;
                end
                slot = (ring_head + ring_fill) % TABLE_DEPTH;
                ring_local_id[slot]  = ring_next_id;
                ring_client_id[slot] = qid;
                ring_addr[slot]      = addr;
                ring_port[slot]      = port;
                ring_stamp[slot]     = now;
                ring_fill++;
                r.status     = dnsr_pkg::STAT_ADDED;
                r.id         = ring_next_id;
                ring_next_id = ring_next_id + 16'd1;
                return 1'b1;
            end
            dnsr_pkg::CMD_FIND: begin
                r.status = dnsr_pkg::STAT_REPLY_MISS;
                for (int k = 0; k < ring_fill; k++) begin
                    slot = (ring_head + k) % TABLE_DEPTH;
                    if (ring_local_id[slot] == qid) begin
                        r.status = dnsr_pkg::STAT_REPLY_HIT;
                        r.id     = ring_client_id[slot];
                        r.addr   = ring_addr[slot];
                        r.port   = ring_port[slot];
                        return 1'b1;
                    end
                end
                return 1'b1;
            end
            dnsr_pkg::CMD_SWEEP: begin
                // plain unsigned compare, the cutoff may wrap
                cutoff = now - rule_age_s * dnsr_pkg::AGE_SCALE_MS;
                while (ring_fill > 0 &&
                       (ring_stamp[ring_head] < cutoff || ring_fill > int'(rule_keep))) begin
                    ring_head = (ring_head + 1) % TABLE_DEPTH;
                    ring_fill--;
                    r.removed = r.removed + 4'd1;
                end
                r.status = dnsr_pkg::STAT_SWEEP_DONE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_field(input string field, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        mismatches++;
    endtask

    // result checking and watchdog
    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("dns_relay_query_id_table_unit_tb: FAIL");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = dnsr_pkg::status_t'(m_tuser);
            got.id      = m_tdata[15:0];
            got.addr    = m_tdata[47:16];
            got.port    = m_tdata[63:48];
            got.removed = m_tdata[67:64];
            if (pending_replies.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got status %0d id %0h",
                         $time, m_tuser, got.id);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)   report_field("status", want.status, got.status);
                if (got.id !== want.id)           report_field("id_out", want.id, got.id);
                if (got.addr !== want.addr)       report_field("addr_out", want.addr, got.addr);
                if (got.port !== want.port)       report_field("port_out", want.port, got.port);
                if (got.removed !== want.removed)
                    report_field("removed_count", want.removed, got.removed);
            end
        end
    end

    // receiver: random back-pressure plus one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_ticket) begin
                m_tready <= 1'b0;
                hold_served++;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] qid,
                             input logic [31:0] addr, input logic [15:0] port,
                             input logic [31:0] now, input bit typed = 1'b0,
                             input reply_t typed_reply = '0);
        reply_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, port, addr, qid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (relay_table_step(cmd, qid, addr, port, now, want))
            pending_replies.push_back(typed ? typed_reply : want);
        @(negedge aclk);
    endtask

    // stop offering and let every outstanding result (and a dropped command) clear
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == dnsr_pkg::REG_AGE_SECONDS)
            rule_age_s = val;
        else
            rule_keep = val[3:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [15:0] qid;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] now_v;
        logic [31:0] clock_ms;
        int          roll;
        int          pick;
        int          n;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        clock_ms  = 32'd300000;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].qid, directed_rows[i].addr,
                      directed_rows[i].port, directed_rows[i].now, directed_rows[i].typed,
                      directed_rows[i].reply);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            send_idle_pct = (ph < 2) ? 18 : ((ph < 4) ? 59 : 0);
            recv_idle_pct = (ph < 2) ? 59 : ((ph < 4) ? 18 : 0);
            write_reg(dnsr_pkg::REG_AGE_SECONDS, 16'(phase_age[ph]));
            write_reg(dnsr_pkg::REG_KEEP_LIMIT, 16'(phase_keep[ph]));
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 90) begin
                    clock_ms = clock_ms + $urandom_range(0, 4000);
                    now_v    = clock_ms;
                end else if (roll < 95) begin
                    clock_ms = $urandom();
                    now_v    = clock_ms;
                end else begin
                    now_v = $urandom();
                end
                addr = $urandom();
                port = 16'($urandom_range(0, 65535));
                qid  = 16'($urandom_range(0, 65535));
                pick = (ring_fill > 0) ?
                       (ring_head + $urandom_range(0, ring_fill - 1)) % TABLE_DEPTH : 0;
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    cmd = dnsr_pkg::CMD_ADD;
                    // reuse a held client id to force a retransmission hit
                    if (ring_fill > 0 && $urandom_range(0, 99) < 40)
                        qid = ring_client_id[pick];
                end else if (roll < 75) begin
                    cmd  = dnsr_pkg::CMD_FIND;
                    roll = $urandom_range(0, 99);
                    if (ring_fill > 0 && roll < 60)
                        qid = ring_local_id[pick];
                    else if (roll < 80)
                        qid = ring_next_id - 16'($urandom_range(1, 12));
                end else if (roll < 94) begin
                    cmd = dnsr_pkg::CMD_SWEEP;
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_item(cmd, qid, addr, port, now_v);
                if (cmd != CMD_UNUSED) begin
                    n++;
                    if (ph == 0 && n == 20)
                        hold_ticket++;
                    if (ph == 2 && n == 30)
                        drain_replies();
                end
            end
        end

        drain_replies();
        if (mismatches == 0)
            $display("dns_relay_query_id_table_unit_tb: PASS");
        else
            $display("dns_relay_query_id_table_unit_tb: FAIL");
        $finish;
    end

endmodule
